FILE: rtl/weighted_fifo_keyed_pool_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the weighted FIFO keyed pool
// Shared concurrent-assertion shorthands, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef WEIGHTED_FIFO_KEYED_POOL_ASSERT_SVH
`define WEIGHTED_FIFO_KEYED_POOL_ASSERT_SVH

// same-cycle implication
`define WFKP_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define WFKP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/wfkp_pkg.sv
// ----------------------------------------------------------------------------
// wfkp_pkg
// Types and constants of the weighted FIFO keyed pool.
// ----------------------------------------------------------------------------
package wfkp_pkg;

	// DEPTH must be a power of two (circular addressing wraps by mask)
	localparam int DEPTH    = 64;
	localparam int KEY_BITS = 64;
	localparam int ADDR_W   = $clog2(DEPTH);
	localparam int CNT_W    = $clog2(DEPTH + 1);

	localparam logic [15:0] WEIGHT_LIMIT_RST = 16'd4096;

	localparam logic [1:0] MODE_ADD    = 2'd0;
	localparam logic [1:0] MODE_REMOVE = 2'd1;
	localparam logic [1:0] MODE_LOOKUP = 2'd2;
	localparam logic [1:0] MODE_NOP    = 2'd3;

	typedef struct packed {
		logic [1:0]  mode;
		logic [63:0] entry_key;
		logic [9:0]  entry_weight;
		logic [15:0] entry_handle;
	} wfkp_req_t;

	typedef struct packed {
		logic        success;
		logic [15:0] found_handle;
		logic [9:0]  found_weight;
		logic [6:0]  evicted_count;
		logic [6:0]  entry_count;
		logic [16:0] total_weight;
	} wfkp_rsp_t;

	typedef struct packed {
		logic [KEY_BITS-1:0] key;
		logic [9:0]          weight;
		logic [15:0]         handle;
	} wfkp_entry_t;

	localparam int ENTRY_W = $bits(wfkp_entry_t);

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		wfkp_entry_t       wdata;
	} wfkp_wr_t;

endpackage

FILE: rtl/weighted_fifo_keyed_pool.sv
// Lookup/remove scan one entry per cycle; remove then compacts by shifting
// each later entry down one slot; add scans, evicts the oldest entry if the
// pool is full, appends, then evicts oldest entries while over the limit.
// One item in flight; the single RAM read port bounds the rate.
// Reset clears count, total and head at once; weight_limit resets to 4096.
// ----------------------------------------------------------------------------
// weighted_fifo_keyed_pool
// Keyed pool in insertion order with weight-limited oldest-first eviction.
// ----------------------------------------------------------------------------
module weighted_fifo_keyed_pool (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  wfkp_pkg::wfkp_req_t req,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output wfkp_pkg::wfkp_rsp_t rsp,
	input  logic                cfg_we,
	input  logic [15:0]         cfg_wdata
);
	import wfkp_pkg::*;

	logic [15:0]       weight_limit_q;
	wfkp_wr_t          ram_wr;
	logic [ADDR_W-1:0] ram_raddr;
	logic [ENTRY_W-1:0] ram_rdata_raw;
	wfkp_entry_t       ram_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weight_limit_q <= WEIGHT_LIMIT_RST;
		end else if (cfg_we) begin
			weight_limit_q <= cfg_wdata;
		end
	end

	assign ram_rdata = wfkp_entry_t'(ram_rdata_raw);

	wfkp_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_wr.we),
		.waddr (ram_wr.waddr),
		.wdata (ram_wr.wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata_raw)
	);

	wfkp_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_valid),
		.req_ready    (req_ready),
		.req          (req),
		.rsp_valid    (rsp_valid),
		.rsp_ready    (rsp_ready),
		.rsp          (rsp),
		.weight_limit (weight_limit_q),
		.ram_wr       (ram_wr),
		.ram_raddr    (ram_raddr),
		.ram_rdata    (ram_rdata)
	);

endmodule

FILE: rtl/wfkp_ram.sv
// ----------------------------------------------------------------------------
// wfkp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module wfkp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: rtl/wfkp_ctrl.sv
// ----------------------------------------------------------------------------
// wfkp_ctrl
// Sequencer for the pool: key scan, append, oldest-first eviction, compaction.
// Entries sit in the RAM in age order from a circular head pointer.
// ----------------------------------------------------------------------------
`include "weighted_fifo_keyed_pool_assert.svh"

module wfkp_ctrl (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         req_valid,
	output logic                         req_ready,
	input  wfkp_pkg::wfkp_req_t          req,
	output logic                         rsp_valid,
	input  logic                         rsp_ready,
	output wfkp_pkg::wfkp_rsp_t          rsp,
	input  logic [15:0]                  weight_limit,
	output wfkp_pkg::wfkp_wr_t           ram_wr,
	output logic [wfkp_pkg::ADDR_W-1:0]  ram_raddr,
	input  wfkp_pkg::wfkp_entry_t        ram_rdata
);
	import wfkp_pkg::*;

	typedef enum logic [8:0] {
		ST_IDLE   = 9'b000000001,
		ST_SEARCH = 9'b000000010,
		ST_EVRD   = 9'b000000100,
		ST_EVSUB  = 9'b000001000,
		ST_APPEND = 9'b000010000,
		ST_TRIM   = 9'b000100000,
		ST_SHRD   = 9'b001000000,
		ST_SHWR   = 9'b010000000,
		ST_DONE   = 9'b100000000
	} state_t;

	state_t            state_q;
	wfkp_req_t         req_q;
	logic [ADDR_W-1:0] head_q;
	logic [CNT_W-1:0]  count_q;
	logic [16:0]       total_q;
	logic [CNT_W-1:0]  idx_q;
	logic [CNT_W-1:0]  cmp_pos_q;
	logic              cmp_vld_q;
	logic [CNT_W-1:0]  pos_q;
	logic              appended_q;
	logic [6:0]        evicted_q;
	logic              success_q;
	logic [15:0]       fh_q;
	logic [9:0]        fw_q;
	logic              rsp_valid_q;
	wfkp_rsp_t         rsp_q;

	logic              hit;
	logic              scan_end;
	logic [CNT_W-1:0]  pos_nx;

	assign hit      = cmp_vld_q && (ram_rdata.key == req_q.entry_key[KEY_BITS-1:0]);
	assign scan_end = !hit && (idx_q >= count_q);
	assign pos_nx   = pos_q + 1'b1;

	always_comb begin
		ram_raddr = head_q + idx_q[ADDR_W-1:0];
		ram_wr    = '0;
		unique case (state_q)
			ST_EVRD: ram_raddr = head_q;
			ST_SHRD: ram_raddr = head_q + pos_nx[ADDR_W-1:0];
			default: ;
		endcase
		if (state_q == ST_APPEND) begin
			ram_wr.we     = 1'b1;
			ram_wr.waddr  = head_q + count_q[ADDR_W-1:0];
			ram_wr.wdata  = '{key: req_q.entry_key[KEY_BITS-1:0],
				weight: req_q.entry_weight, handle: req_q.entry_handle};
		end else if (state_q == ST_SHWR) begin
			ram_wr.we    = 1'b1;
			ram_wr.waddr = head_q + pos_q[ADDR_W-1:0];
			ram_wr.wdata = ram_rdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			head_q      <= '0;
			count_q     <= '0;
			total_q     <= '0;
			idx_q       <= '0;
			cmp_pos_q   <= '0;
			cmp_vld_q   <= 1'b0;
			pos_q       <= '0;
			appended_q  <= 1'b0;
			evicted_q   <= '0;
			success_q   <= 1'b0;
			fh_q        <= '0;
			fw_q        <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			// output register: loads a new beat or drains the accepted one
			if (state_q == ST_DONE && (!rsp_valid_q || rsp_ready)) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						idx_q      <= '0;
						cmp_vld_q  <= 1'b0;
						appended_q <= 1'b0;
						evicted_q  <= '0;
						success_q  <= 1'b0;
						fh_q       <= '0;
						fw_q       <= '0;
						state_q    <= (req.mode == MODE_NOP) ? ST_DONE : ST_SEARCH;
					end
				end
				ST_SEARCH: begin
					if (hit) begin
						cmp_vld_q <= 1'b0;
						if (req_q.mode == MODE_REMOVE) begin
							total_q <= total_q - {7'd0, ram_rdata.weight};
							pos_q   <= cmp_pos_q;
							state_q <= ST_SHRD;
						end else if (req_q.mode == MODE_LOOKUP) begin
							success_q <= 1'b1;
							fh_q      <= ram_rdata.handle;
							fw_q      <= ram_rdata.weight;
							state_q   <= ST_DONE;
						end else begin
							state_q <= ST_DONE;   // duplicate add
						end
					end else if (scan_end) begin
						cmp_vld_q <= 1'b0;
						if (req_q.mode == MODE_ADD) begin
							state_q <= (count_q == CNT_W'(DEPTH)) ? ST_EVRD : ST_APPEND;
						end else begin
							state_q <= ST_DONE;
						end
					end else begin
						cmp_pos_q <= idx_q;
						cmp_vld_q <= 1'b1;
						idx_q     <= idx_q + 1'b1;
					end
				end
				ST_EVRD: state_q <= ST_EVSUB;
				ST_EVSUB: begin
					total_q   <= total_q - {7'd0, ram_rdata.weight};
					head_q    <= head_q + 1'b1;
					count_q   <= count_q - 1'b1;
					evicted_q <= evicted_q + 1'b1;
					state_q   <= appended_q ? ST_TRIM : ST_APPEND;
				end
				ST_APPEND: begin
					count_q    <= count_q + 1'b1;
					total_q    <= total_q + {7'd0, req_q.entry_weight};
					appended_q <= 1'b1;
					state_q    <= ST_TRIM;
				end
				ST_TRIM: begin
					if (total_q > {1'b0, weight_limit} && count_q != '0) begin
						state_q <= ST_EVRD;
					end else begin
						success_q <= 1'b1;
						state_q   <= ST_DONE;
					end
				end
				ST_SHRD: begin
					if (pos_nx < count_q) begin
						state_q <= ST_SHWR;
					end else begin
						count_q   <= count_q - 1'b1;
						success_q <= 1'b1;
						state_q   <= ST_DONE;
					end
				end
				ST_SHWR: begin
					pos_q   <= pos_nx;
					state_q <= ST_SHRD;
				end
				ST_DONE: begin
					if (!rsp_valid_q || rsp_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && req_valid) begin
			req_q <= req;
		end
		if (state_q == ST_DONE && (!rsp_valid_q || rsp_ready)) begin
			rsp_q.success       <= success_q;
			rsp_q.found_handle  <= fh_q;
			rsp_q.found_weight  <= fw_q;
			rsp_q.evicted_count <= evicted_q;
			rsp_q.entry_count   <= 7'(count_q);
			rsp_q.total_weight  <= total_q;
		end
	end

	assign req_ready = (state_q == ST_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	`WFKP_ASSERT_NOW(a_count_max, 1'b1, count_q <= CNT_W'(DEPTH),
		"entry count above depth")
	`WFKP_ASSERT_NOW(a_empty_total, count_q == '0, total_q == '0,
		"empty pool with nonzero total")
	`WFKP_ASSERT_NOW(a_trim_done, state_q == ST_TRIM && success_q == 1'b0 &&
		!(total_q > {1'b0, weight_limit} && count_q != '0) && appended_q,
		total_q <= {1'b0, weight_limit} || count_q == '0, "trim left total above limit")
	`WFKP_ASSERT_NEXT(a_evict_add_only, state_q == ST_DONE && req_q.mode != MODE_ADD,
		evicted_q == '0, "eviction outside an add")

endmodule

FILE: tb/weighted_fifo_keyed_pool_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// weighted_fifo_keyed_pool_tb
// Drives add, remove, lookup and no-op beats into the keyed pool under random idle
// cycles on both sides, predicts each response with a behavioral pool model
// and compares it field by field. The weight limit is changed between phases.
// ----------------------------------------------------------------------------
module weighted_fifo_keyed_pool_tb;
	import wfkp_pkg::*;

	localparam int N_RANDOM  = 965;
	localparam int CYC_LIMIT = 2000000;
	localparam int DRAIN_CYC = 4 * DEPTH + 20;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	wfkp_req_t req;
	logic rsp_valid;
	logic rsp_ready;
	wfkp_rsp_t rsp;
	logic cfg_we;
	logic [15:0] cfg_wdata;

	weighted_fifo_keyed_pool u_top (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_ready(req_ready), .req(req),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	// pool model: age-ordered list of entries
	logic [63:0] pool_key[$];
	logic [9:0]  pool_weight[$];
	logic [15:0] pool_handle[$];
	logic [16:0] pool_total;
	logic [15:0] limit_reg;

	wfkp_rsp_t rsp_expected[$];
	int errors;
	int cycles;
	bit quiet_tx, quiet_rx;

	typedef struct {
		wfkp_req_t r;
		bit        has_exp;
		wfkp_rsp_t e;
	} dir_row_t;

	function automatic int pool_find(logic [63:0] k);
		for (int i = 0; i < pool_key.size(); i++)
			if (pool_key[i] == k) return i;
		return -1;
	endfunction

	function automatic void pool_drop(int p);
		pool_total -= pool_weight[p];
		pool_key.delete(p);
		pool_weight.delete(p);
		pool_handle.delete(p);
	endfunction

	function automatic wfkp_rsp_t pool_apply(wfkp_req_t r);
		wfkp_rsp_t o;
		int p;
		o = '0;
		p = pool_find(r.entry_key);
		case (r.mode)
			MODE_ADD: begin
				if (p < 0) begin
					if (pool_key.size() >= DEPTH) begin
						pool_drop(0);
						o.evicted_count++;
					end
					pool_key.insert(pool_key.size(), r.entry_key);
					pool_weight.insert(pool_weight.size(), r.entry_weight);
					pool_handle.insert(pool_handle.size(), r.entry_handle);
					pool_total += r.entry_weight;
					while (pool_total > limit_reg && pool_key.size() > 0) begin
						pool_drop(0);
						o.evicted_count++;
					end
					o.success = 1'b1;
				end
			end
			MODE_REMOVE: begin
				if (p >= 0) begin
					pool_drop(p);
					o.success = 1'b1;
				end
			end
			MODE_LOOKUP: begin
				if (p >= 0) begin
					o.found_handle = pool_handle[p];
					o.found_weight = pool_weight[p];
					o.success = 1'b1;
				end
			end
			default: ;
		endcase
		o.entry_count = 7'(pool_key.size());
		o.total_weight = pool_total;
		return o;
	endfunction

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYC_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// response side: random stall, check on accepted beat
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ready <= 1'b0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (rsp_expected.size() == 0) begin
					$error("unexpected response beat");
					errors++;
				end else begin
					wfkp_rsp_t e;
					e = rsp_expected.pop_front();
					if (rsp.success !== e.success) begin
						$error("success exp %0h got %0h", e.success, rsp.success);
						errors++;
					end
					if (rsp.found_handle !== e.found_handle) begin
						$error("found_handle exp %0h got %0h", e.found_handle,
							rsp.found_handle);
						errors++;
					end
					if (rsp.found_weight !== e.found_weight) begin
						$error("found_weight exp %0h got %0h", e.found_weight,
							rsp.found_weight);
						errors++;
					end
					if (rsp.evicted_count !== e.evicted_count) begin
						$error("evicted_count exp %0d got %0d", e.evicted_count,
							rsp.evicted_count);
						errors++;
					end
					if (rsp.entry_count !== e.entry_count) begin
						$error("entry_count exp %0d got %0d", e.entry_count,
							rsp.entry_count);
						errors++;
					end
					if (rsp.total_weight !== e.total_weight) begin
						$error("total_weight exp %0d got %0d", e.total_weight,
							rsp.total_weight);
						errors++;
					end
				end
			end
			rsp_ready <= quiet_rx ? 1'b1 : ($urandom_range(99) >= 26);
		end
	end

	// valid stays up after the accepting edge until the next beat or an idle cycle
	task automatic send_beat(wfkp_req_t r, bit has_exp, wfkp_rsp_t e);
		wfkp_rsp_t p;
		while (!quiet_tx && $urandom_range(99) < 26) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		p = pool_apply(r);
		if (has_exp && p != e) begin
			$error("table row disagrees with pool model: exp %h model %h", e, p);
			errors++;
		end
		rsp_expected.insert(rsp_expected.size(), p);
		req_valid <= 1'b1;
		req <= r;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
	endtask

	task automatic wait_idle();
		req_valid <= 1'b0;
		while (rsp_expected.size() != 0) @(posedge clk);
		repeat (DRAIN_CYC) @(posedge clk);
	endtask

	task automatic set_limit(logic [15:0] v);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		limit_reg = v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic wfkp_req_t mk(logic [1:0] m, logic [63:0] k, logic [9:0] w,
		logic [15:0] h);
		wfkp_req_t r;
		r.mode = m;
		r.entry_key = k;
		r.entry_weight = w;
		r.entry_handle = h;
		return r;
	endfunction

	function automatic wfkp_rsp_t ex(bit s, logic [15:0] fh, logic [9:0] fw,
		logic [6:0] ev, logic [6:0] n, logic [16:0] t);
		wfkp_rsp_t o;
		o.success = s;
		o.found_handle = fh;
		o.found_weight = fw;
		o.evicted_count = ev;
		o.entry_count = n;
		o.total_weight = t;
		return o;
	endfunction

	initial begin
		dir_row_t rows[$];
		wfkp_req_t r;
		logic [63:0] keys[$];
		logic [63:0] k;
		int sel;
		cycles = 0;
		errors = 0;
		quiet_tx = 0;
		quiet_rx = 0;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		pool_total = '0;
		limit_reg = WEIGHT_LIMIT_RST;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table; expectations only where obvious
		rows.insert(rows.size(), '{mk(MODE_LOOKUP, 64'h0, 10'h0, 16'h0), 1,
			ex(0, 0, 0, 0, 0, 0)});
		rows.insert(rows.size(), '{mk(MODE_REMOVE, '1, 10'h0, 16'h0), 1,
			ex(0, 0, 0, 0, 0, 0)});
		rows.insert(rows.size(), '{mk(MODE_NOP, '1, '1, '1), 1, ex(0, 0, 0, 0, 0, 0)});
		rows.insert(rows.size(), '{mk(MODE_ADD, '1, 10'd1023, 16'hffff), 1,
			ex(1, 0, 0, 0, 1, 1023)});
		rows.insert(rows.size(), '{mk(MODE_ADD, '1, 10'd5, 16'h1), 1,
			ex(0, 0, 0, 0, 1, 1023)});
		rows.insert(rows.size(), '{mk(MODE_LOOKUP, '1, 10'h0, 16'h0), 1,
			ex(1, 16'hffff, 10'd1023, 0, 1, 1023)});
		rows.insert(rows.size(), '{mk(MODE_ADD, 64'h0, 10'd0, 16'h0), 1,
			ex(1, 0, 0, 0, 2, 1023)});
		rows.insert(rows.size(), '{mk(MODE_ADD, 64'h8000_0000_0000_0000, 10'd1023,
			16'h8000), 0, ex(0, 0, 0, 0, 0, 0)});
		rows.insert(rows.size(), '{mk(MODE_ADD, 64'h5555_aaaa_5555_aaaa, 10'd1023,
			16'haaaa), 0, ex(0, 0, 0, 0, 0, 0)});
		rows.insert(rows.size(), '{mk(MODE_ADD, 64'h1, 10'd1023, 16'h5555), 0,
			ex(0, 0, 0, 0, 0, 0)});
		rows.insert(rows.size(), '{mk(MODE_ADD, 64'h2, 10'd1023, 16'h2), 0,
			ex(0, 0, 0, 0, 0, 0)});
		rows.insert(rows.size(), '{mk(MODE_LOOKUP, 64'h0, 10'h0, 16'h0), 0,
			ex(0, 0, 0, 0, 0, 0)});
		rows.insert(rows.size(), '{mk(MODE_REMOVE, 64'h1, 10'h0, 16'h0), 0,
			ex(0, 0, 0, 0, 0, 0)});
		rows.insert(rows.size(), '{mk(MODE_REMOVE, 64'h1, 10'h0, 16'h0), 0,
			ex(0, 0, 0, 0, 0, 0)});
		rows.insert(rows.size(), '{mk(MODE_NOP, 64'h0, 10'h0, 16'h0), 0,
			ex(0, 0, 0, 0, 0, 0)});
		foreach (rows[i])
			send_beat(rows[i].r, rows[i].has_exp, rows[i].e);

		// zero limit: every add of nonzero weight evicts itself and the rest
		set_limit(16'd0);
		send_beat(mk(MODE_ADD, 64'h33, 10'd7, 16'h7), 0, '0);
		send_beat(mk(MODE_ADD, 64'h34, 10'd0, 16'h8), 1, ex(1, 0, 0, 0, 1, 0));
		send_beat(mk(MODE_ADD, 64'h35, 10'd1, 16'h9), 1, ex(1, 0, 0, 2, 0, 0));

		// max limit, then fill past DEPTH to force full-pool eviction
		set_limit(16'hffff);
		for (int i = 0; i < DEPTH + 3; i++)
			send_beat(mk(MODE_ADD, 64'h1000 + i, 10'($urandom), 16'($urandom)), 0, '0);

		// random phases over several limits
		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: set_limit(16'd4096);
				1: set_limit(16'd1500);
				2: set_limit(16'($urandom_range(65535)));
				3: set_limit(16'd40000);
				default: set_limit(16'($urandom_range(3000)));
			endcase
			quiet_tx = (ph == 2);
			quiet_rx = (ph == 2);
			for (int n = 0; n < N_RANDOM / 5; n++) begin
				sel = $urandom_range(99);
				if (keys.size() == 0 || sel < 10)
					k = {$urandom, $urandom};
				else
					k = keys[$urandom_range(keys.size() - 1)];
				if (keys.size() < 96) keys.insert(keys.size(), k);
				else keys[$urandom_range(95)] = k;
				r = mk(sel < 50 ? MODE_ADD : sel < 70 ? MODE_REMOVE :
					sel < 95 ? MODE_LOOKUP : MODE_NOP,
					k, 10'($urandom_range(ph == 3 ? 1023 : 200)), 16'($urandom));
				send_beat(r, 0, '0);
			end
		end
		quiet_tx = 0;
		quiet_rx = 0;

		wait_idle();
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule
